>>> hdl/thti_pkg.sv
// shared types, codes and constants for the three-hourly temperature interpolation unit
`timescale 1ns / 1ps

package thti_pkg;

   // operation codes carried on req_opcode
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   // eight three-hour periods per day
   localparam int PERIODS    = 8;
   localparam int PERIOD_W   = 3;

   // restoring divider: quotient magnitude always fits 17 bits
   localparam int DIV_STEPS  = 17;
   localparam int DIV_CNT_W  = 5;

   // sum of eight q8.8 values
   localparam int SUM_W      = 19;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_DEV,
      ST_ROUND,
      ST_TEMP,
      ST_SEARCH,
      ST_MUL_INT,
      ST_DIV_SETUP,
      ST_DIV,
      ST_APPLY,
      ST_ACC,
      ST_MEAN
   } state_type;

   // diurnal shape fraction per period, unsigned q0.16
   function automatic logic [15:0] frac_q16(input logic [PERIOD_W-1:0] period);
      logic [15:0] f;
      unique case (period)
         3'd0:    f = 16'd63573;
         3'd1:    f = 16'd59654;
         3'd2:    f = 16'd50689;
         3'd3:    f = 16'd38761;
         3'd4:    f = 16'd25956;
         3'd5:    f = 16'd14356;
         3'd6:    f = 16'd6046;
         3'd7:    f = 16'd3110;
         default: f = 16'd0;
      endcase
      return f;
   endfunction

endpackage

>>> hdl/three_hourly_temperature_interpolation_unit.sv
// top level: breakpoint table, sequencer and shared multiply / divide datapath
`timescale 1ns / 1ps

//  channel   ports                           direction  beat accepted when
//  request   start busy req_*                in         start && !busy
//  response  rsp_valid rsp_daily_factor      out        rsp_valid (one cycle, no stall)
//  csr       csr_wr_en csr_wr_data           in         csr_wr_en
//
//  a write beat goes into the table as it is accepted and leaves busy low
//  a query beat holds busy through eight periods; in each, the entries are scanned (1 to
//  points_in_use, one per cycle), and when the period falls between two breakpoints the
//  one-bit-a-cycle divider runs as well
//  reset is synchronous and clears the sequencer and sets points_in_use to 1; table contents
//  stay undefined until written
//  the receiver cannot stall: the response beat is a single-cycle strobe as busy drops

module three_hourly_temperature_interpolation_unit #(
   parameter int MAX_POINTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic        [3:0]  req_point_index,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic signed [15:0] req_tmax,
   input  logic signed [15:0] req_tmin,
   // response channel
   output logic               rsp_valid,
   output logic signed [15:0] rsp_daily_factor,
   // register write
   input  logic               csr_wr_en,
   input  logic        [4:0]  csr_wr_data
);

   localparam int AW = $clog2(MAX_POINTS);

   // sequencer
   thti_pkg::state_type state_ff, state_in;

   // configuration
   logic [4:0] csr_pts_ff, csr_pts_in;

   // query context
   logic signed [15:0] tmin_ff, tmin_in;
   logic signed [16:0] range_ff, range_in;
   logic [thti_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic signed [thti_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [AW-1:0] last_ff, last_in;

   // table scan
   logic [AW-1:0]      cur_ff, cur_in;
   logic [31:0]        bp_rd_ff;
   logic signed [15:0] prev_x_ff, prev_x_in;
   logic signed [15:0] prev_y_ff, prev_y_in;

   // per-period arithmetic
   logic signed [17:0] dev_ff, dev_in;
   logic signed [17:0] t_ff, t_in;
   logic signed [33:0] prod_ff, prod_in;
   logic        [15:0] dx_ff, dx_in;
   logic signed [16:0] dy_ff, dy_in;
   logic signed [16:0] dist_ff, dist_in;
   logic signed [15:0] y0_ff, y0_in;
   logic               neg_ff, neg_in;
   logic        [16:0] rem_ff, rem_in;
   logic        [16:0] quo_ff, quo_in;
   logic [thti_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic signed [15:0] val_ff, val_in;

   // response
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_factor_ff, rsp_factor_in;

   // breakpoint table: {x, y} per slot, one write port, one registered read port
   logic [31:0] bp_mem [MAX_POINTS];

   logic accept;
   logic wr_slot_ok;

   assign accept     = start && !busy;
   assign wr_slot_ok = 32'(req_point_index) < MAX_POINTS;

   always_ff @(posedge clock) begin
      if (accept && req_opcode == thti_pkg::OP_WRITE && wr_slot_ok) begin
         bp_mem[AW'(req_point_index)] <= {req_point_x, req_point_y};
      end
      bp_rd_ff <= bp_mem[cur_in];
   end

   // ---------------------------------------------------------------- decode of the scanned entry
   logic signed [15:0] cur_x, cur_y;
   logic signed [17:0] cur_x_ext;
   logic               scan_hit, scan_exact, scan_first, scan_last;
   logic signed [16:0] dx_full, dy_full;
   logic signed [18:0] dist_full;
   logic               gap_bad;

   assign cur_x      = signed'(bp_rd_ff[31:16]);
   assign cur_y      = signed'(bp_rd_ff[15:0]);
   assign cur_x_ext  = 18'(cur_x);
   assign scan_hit   = t_ff <= cur_x_ext;
   assign scan_exact = t_ff == cur_x_ext;
   assign scan_first = cur_ff == '0;
   assign scan_last  = cur_ff == last_ff;
   assign dx_full    = 17'(cur_x) - 17'(prev_x_ff);
   assign dy_full    = 17'(cur_y) - 17'(prev_y_ff);
   assign dist_full  = 19'(t_ff) - 19'(prev_x_ff);
   assign gap_bad    = dx_full[16] || dx_full == '0;

   // ---------------------------------------------------------------- shared multiplier
   // deviation: frac * range; interpolation: dy * (t - x0)
   logic signed [16:0] mul_a, mul_b;
   logic signed [33:0] mul_p;

   always_comb begin
      if (state_ff == thti_pkg::ST_MUL_DEV) begin
         mul_a = signed'({1'b0, thti_pkg::frac_q16(period_ff)});
         mul_b = range_ff;
      end else begin
         mul_a = dy_ff;
         mul_b = dist_ff;
      end
   end

   assign mul_p = mul_a * mul_b;

   // magnitude of the product, shared by the deviation rounding and the divider setup
   logic [33:0] prod_mag;
   logic [33:0] dev_rnd;
   logic [33:0] div_mag;

   assign prod_mag = prod_ff[33] ? 34'(-prod_ff) : 34'(prod_ff);
   assign dev_rnd  = prod_mag + 34'd32768;
   assign div_mag  = prod_mag + 34'(dx_ff >> 1);

   // one restoring step per cycle
   logic [16:0] div_shift;
   logic        div_ge;

   assign div_shift = {rem_ff[15:0], quo_ff[16]};
   assign div_ge    = div_shift >= {1'b0, dx_ff};

   // signed quotient and rounded mean
   logic signed [17:0] q_signed;
   logic [thti_pkg::SUM_W-1:0] sum_mag, mean_rnd;
   logic [15:0] mean_mag;

   assign q_signed = neg_ff ? -signed'({1'b0, quo_ff}) : signed'({1'b0, quo_ff});
   assign sum_mag  = sum_ff[thti_pkg::SUM_W-1] ? thti_pkg::SUM_W'(-sum_ff)
                                              : thti_pkg::SUM_W'(sum_ff);
   assign mean_rnd = sum_mag + thti_pkg::SUM_W'(4);
   assign mean_mag = mean_rnd[thti_pkg::SUM_W-1:3];

   // clamp of points_in_use to the table depth, as a last index
   logic [AW-1:0] last_calc;

   always_comb begin
      if (32'(csr_pts_ff) > MAX_POINTS) begin
         last_calc = AW'(MAX_POINTS - 1);
      end else if (csr_pts_ff == '0) begin
         last_calc = '0;
      end else begin
         last_calc = AW'(csr_pts_ff - 5'd1);
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         thti_pkg::ST_IDLE: begin
            if (accept && req_opcode == thti_pkg::OP_EVAL) begin
               state_in = thti_pkg::ST_MUL_DEV;
            end
         end
         thti_pkg::ST_MUL_DEV:   state_in = thti_pkg::ST_ROUND;
         thti_pkg::ST_ROUND:     state_in = thti_pkg::ST_TEMP;
         thti_pkg::ST_TEMP:      state_in = thti_pkg::ST_SEARCH;
         thti_pkg::ST_SEARCH: begin
            if (scan_hit) begin
               if (scan_first || scan_exact || gap_bad) begin
                  state_in = thti_pkg::ST_ACC;
               end else begin
                  state_in = thti_pkg::ST_MUL_INT;
               end
            end else if (scan_last) begin
               state_in = thti_pkg::ST_ACC;
            end
         end
         thti_pkg::ST_MUL_INT:   state_in = thti_pkg::ST_DIV_SETUP;
         thti_pkg::ST_DIV_SETUP: state_in = thti_pkg::ST_DIV;
         thti_pkg::ST_DIV: begin
            if (div_cnt_ff == thti_pkg::DIV_CNT_W'(thti_pkg::DIV_STEPS - 1)) begin
               state_in = thti_pkg::ST_APPLY;
            end
         end
         thti_pkg::ST_APPLY:     state_in = thti_pkg::ST_ACC;
         thti_pkg::ST_ACC: begin
            if (period_ff == thti_pkg::PERIOD_W'(thti_pkg::PERIODS - 1)) begin
               state_in = thti_pkg::ST_MEAN;
            end else begin
               state_in = thti_pkg::ST_MUL_DEV;
            end
         end
         thti_pkg::ST_MEAN:      state_in = thti_pkg::ST_IDLE;
         default:                state_in = thti_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath next values
   always_comb begin
      csr_pts_in    = csr_wr_en ? csr_wr_data : csr_pts_ff;
      tmin_in       = tmin_ff;
      range_in      = range_ff;
      period_in     = period_ff;
      sum_in        = sum_ff;
      last_in       = last_ff;
      cur_in        = '0;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      dev_in        = dev_ff;
      t_in          = t_ff;
      prod_in       = prod_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      dist_in       = dist_ff;
      y0_in         = y0_ff;
      neg_in        = neg_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      val_in        = val_ff;
      rsp_valid_in  = 1'b0;
      rsp_factor_in = rsp_factor_ff;

      unique case (state_ff)
         thti_pkg::ST_IDLE: begin
            if (accept && req_opcode == thti_pkg::OP_EVAL) begin
               tmin_in   = req_tmin;
               range_in  = 17'(req_tmax) - 17'(req_tmin);
               period_in = '0;
               sum_in    = '0;
               last_in   = last_calc;
            end
         end
         thti_pkg::ST_MUL_DEV: begin
            prod_in = mul_p;
         end
         thti_pkg::ST_ROUND: begin
            dev_in = prod_ff[33] ? -signed'(dev_rnd[33:16]) : signed'(dev_rnd[33:16]);
         end
         thti_pkg::ST_TEMP: begin
            t_in = 18'(tmin_ff) + dev_ff;
         end
         thti_pkg::ST_SEARCH: begin
            if (scan_hit) begin
               if (scan_first || scan_exact) begin
                  val_in = cur_y;
               end else if (gap_bad) begin
                  val_in = prev_y_ff;
               end else begin
                  dx_in   = dx_full[15:0];
                  dy_in   = dy_full;
                  dist_in = signed'(dist_full[16:0]);
                  y0_in   = prev_y_ff;
               end
            end else if (scan_last) begin
               val_in = cur_y;
            end else begin
               prev_x_in = cur_x;
               prev_y_in = cur_y;
               cur_in    = cur_ff + AW'(1);
            end
         end
         thti_pkg::ST_MUL_INT: begin
            prod_in = mul_p;
         end
         thti_pkg::ST_DIV_SETUP: begin
            // top bits are already below the divisor, so 17 steps give the full quotient
            neg_in     = prod_ff[33];
            rem_in     = div_mag[33:17];
            quo_in     = div_mag[16:0];
            div_cnt_in = '0;
         end
         thti_pkg::ST_DIV: begin
            rem_in     = div_ge ? div_shift - {1'b0, dx_ff} : div_shift;
            quo_in     = {quo_ff[15:0], div_ge};
            div_cnt_in = div_cnt_ff + thti_pkg::DIV_CNT_W'(1);
         end
         thti_pkg::ST_APPLY: begin
            val_in = 16'(18'(y0_ff) + q_signed);
         end
         thti_pkg::ST_ACC: begin
            sum_in    = sum_ff + thti_pkg::SUM_W'(val_ff);
            period_in = period_ff + thti_pkg::PERIOD_W'(1);
         end
         thti_pkg::ST_MEAN: begin
            rsp_valid_in  = 1'b1;
            rsp_factor_in = sum_ff[thti_pkg::SUM_W-1] ? -signed'(mean_mag) : signed'(mean_mag);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= thti_pkg::ST_IDLE;
         csr_pts_ff   <= 5'd1;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_pts_ff   <= csr_pts_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tmin_ff       <= tmin_in;
      range_ff      <= range_in;
      period_ff     <= period_in;
      sum_ff        <= sum_in;
      last_ff       <= last_in;
      prev_x_ff     <= prev_x_in;
      prev_y_ff     <= prev_y_in;
      dev_ff        <= dev_in;
      t_ff          <= t_in;
      prod_ff       <= prod_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      dist_ff       <= dist_in;
      y0_ff         <= y0_in;
      neg_ff        <= neg_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      div_cnt_ff    <= div_cnt_in;
      val_ff        <= val_in;
      rsp_factor_ff <= rsp_factor_in;
   end

   assign busy             = state_ff != thti_pkg::ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_daily_factor = rsp_factor_ff;

   // ---------------------------------------------------------------- assertions
   // a query beat makes the unit busy on the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == thti_pkg::OP_EVAL) |=> busy)
      else $error("query beat did not start the sequencer");

   // the response beat appears only as the sequencer returns to idle, and lasts one cycle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && !$past(rsp_valid)))
      else $error("response beat outside the end of a query");

   // the scan never runs past the last entry in use
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == thti_pkg::ST_SEARCH) |-> (cur_ff <= last_ff))
      else $error("table scan beyond last breakpoint");

   // restoring divider keeps its partial remainder below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == thti_pkg::ST_DIV) |-> (rem_ff < {1'b0, dx_ff}))
      else $error("divider remainder not below divisor");

endmodule

>>> test/tb_top.sv
// self-checking bench for the three-hourly temperature interpolation unit
`timescale 1ns / 1ps

module tb_top;

   localparam int CLK_PERIOD   = 12;
   localparam int RESET_CYCLES = 4;
   localparam int TABLE_SLOTS  = 16;
   // random beats after the directed part
   localparam int RANDOM_BEATS = 450;
   // cycles to wait after the last expected result, in case a stray one follows
   localparam int DRAIN_CYCLES = 400;
   // quiet cycles before a register write once the last result is in
   localparam int SETTLE_CYCLES = 8;
   // worst case is ~500 beats, each a full query plus the longest idle gap; several times that
   localparam int CYCLE_LIMIT  = 1000000;

   // golden model of the unit: its own breakpoint copy and point count
   class daily_factor_scoreboard;
      int bp_x [TABLE_SLOTS];
      int bp_y [TABLE_SLOTS];
      int points_cfg;
      logic signed [15:0] expected_factors [$];
      int mismatches;

      function new();
         points_cfg = 1;
         mismatches = 0;
      endfunction

      function void set_points(int value);
         points_cfg = value & 31;
      endfunction

      // count as the unit sees it: 0 reads as 1, above the table size as full
      function int eff_points();
         if (points_cfg < 1) return 1;
         if (points_cfg > TABLE_SLOTS) return TABLE_SLOTS;
         return points_cfg;
      endfunction

      // nearest, halves away from zero, positive divisor
      function longint round_div(longint num, longint den);
         if (num >= 0) return (num + den / 2) / den;
         return -((-num + den / 2) / den);
      endfunction

      // diurnal shape per period, unsigned q0.16
      function longint frac_of(int period);
         case (period)
            0: return 63573;
            1: return 59654;
            2: return 50689;
            3: return 38761;
            4: return 25956;
            5: return 14356;
            6: return 6046;
            7: return 3110;
            default: return 0;
         endcase
      endfunction

      // piecewise-linear lookup clamped to the end y values
      function longint interpolate_point(longint t, int n);
         int i;
         longint dx;
         longint dy;
         for (i = 0; i < n; i++) begin
            if (t <= bp_x[i]) begin
               if (i == 0 || t == bp_x[i]) return bp_y[i];
               dx = longint'(bp_x[i]) - bp_x[i-1];
               dy = longint'(bp_y[i]) - bp_y[i-1];
               if (dx <= 0) return bp_y[i-1];
               return bp_y[i-1] + round_div(dy * (t - bp_x[i-1]), dx);
            end
         end
         return bp_y[n-1];
      endfunction

      function logic signed [15:0] predict_daily_factor(logic signed [15:0] tmax,
                                                        logic signed [15:0] tmin);
         longint span;
         longint t;
         longint sum;
         longint mean;
         int n;
         int p;
         n    = eff_points();
         span = longint'(tmax) - longint'(tmin);
         sum  = 0;
         for (p = 0; p < thti_pkg::PERIODS; p++) begin
            t   = longint'(tmin) + round_div(frac_of(p) * span, 65536);
            sum += interpolate_point(t, n);
         end
         mean = round_div(sum, thti_pkg::PERIODS);
         return mean[15:0];
      endfunction

      // an accepted request beat: writes update the copy, queries queue a factor
      function void note_beat(logic op, logic [3:0] idx, logic signed [15:0] x,
                              logic signed [15:0] y, logic signed [15:0] tmax,
                              logic signed [15:0] tmin);
         if (op == thti_pkg::OP_WRITE) begin
            bp_x[idx] = x;
            bp_y[idx] = y;
         end else begin
            expected_factors.push_back(predict_daily_factor(tmax, tmin));
         end
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_factor(logic signed [15:0] got);
         logic signed [15:0] want;
         if (expected_factors.size() == 0) begin
            report_mismatch($sformatf("unexpected daily_factor %0d", got));
         end else begin
            want = expected_factors.pop_front();
            if (got !== want)
               report_mismatch($sformatf("daily_factor got %0d want %0d", got, want));
         end
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_opcode;
   logic        [3:0]  req_point_index;
   logic signed [15:0] req_point_x;
   logic signed [15:0] req_point_y;
   logic signed [15:0] req_tmax;
   logic signed [15:0] req_tmin;
   logic               rsp_valid;
   logic signed [15:0] rsp_daily_factor;
   logic               csr_wr_en;
   logic        [4:0]  csr_wr_data;

   daily_factor_scoreboard sb;
   int  beats_sent;
   int  cycle_count;
   int  phase_count;
   bit  no_idle;

   // directed breakpoints: both x extremes, a repeated x, both y extremes
   int dir_x [TABLE_SLOTS] = '{-32768, -20000, -8000, -8000, -2000, 0, 256, 512,
                               1024, 2048, 3000, 5000, 8000, 12000, 20000, 32767};
   int dir_y [TABLE_SLOTS] = '{-32768, 32767, 0, 1000, -1000, 256, 512, -256,
                               300, 700, 1200, -5000, 9000, 100, 20000, 32767};
   // register values at the edges of the 5-bit field and of the table size
   int cfg_extremes [5] = '{0, 1, 16, 17, 31};

   three_hourly_temperature_interpolation_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_point_index  (req_point_index),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_tmax         (req_tmax),
      .req_tmin         (req_tmin),
      .rsp_valid        (rsp_valid),
      .rsp_daily_factor (rsp_daily_factor),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[three_hourly_temperature_interpolation_unit] ERROR");
         $finish;
      end
   end

   // response beats are single-cycle strobes, taken at the edge that ends them
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_factor(rsp_daily_factor);
   end

   function automatic logic signed [15:0] clamp16(int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   // one request beat; called on a rising edge, returns on the edge that took it
   task automatic drive_beat(logic op, logic [3:0] idx, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] tmax,
                             logic signed [15:0] tmin);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_opcode      <= op;
      req_point_index <= idx;
      req_point_x     <= x;
      req_point_y     <= y;
      req_tmax        <= tmax;
      req_tmin        <= tmin;
      // beat goes through at the first edge with busy low
      do @(posedge clock); while (busy);
      sb.note_beat(op, idx, x, y, tmax, tmin);
      beats_sent++;
   endtask

   // unused fields of a beat carry random noise
   task automatic write_point(logic [3:0] idx, logic signed [15:0] x, logic signed [15:0] y);
      drive_beat(thti_pkg::OP_WRITE, idx, x, y, 16'($urandom), 16'($urandom));
   endtask

   task automatic query_day(logic signed [15:0] tmax, logic signed [15:0] tmin);
      drive_beat(thti_pkg::OP_EVAL, 4'($urandom), 16'($urandom), 16'($urandom), tmax, tmin);
   endtask

   // stop issuing, let every query finish, then a short quiet spell
   task automatic wait_for_idle();
      start <= 1'b0;
      while (sb.expected_factors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_points_cfg(int value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[4:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_points(value);
   endtask

   // ascending table with random spacing, the odd repeat and the odd stray x
   task automatic load_random_table();
      int i;
      int x;
      int step_max;
      step_max = 1 << $urandom_range(0, 12);
      x = int'($urandom_range(0, 60000)) - 32768;
      for (i = 0; i < TABLE_SLOTS; i++) begin
         if (i > 0 && $urandom_range(0, 9) != 0) x += $urandom_range(1, step_max);
         if ($urandom_range(0, 19) == 0)
            write_point(4'(i), 16'($urandom), 16'($urandom));
         else
            write_point(4'(i), clamp16(x), 16'($urandom));
      end
   endtask

   // one register setting, maybe a fresh table, then mostly queries around the table
   task automatic run_phase();
      int cfg;
      int n;
      int lo_t;
      int hi_t;
      int a;
      int b;
      int count;
      int k;
      int mode;
      wait_for_idle();
      if (phase_count < 5)
         cfg = cfg_extremes[phase_count];
      else if ($urandom_range(0, 4) == 0)
         cfg = cfg_extremes[$urandom_range(0, 4)];
      else
         cfg = $urandom_range(2, 16);
      write_points_cfg(cfg);
      phase_count++;
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0) load_random_table();
      count = $urandom_range(10, 30);
      for (k = 0; k < count; k++) begin
         n    = sb.eff_points();
         mode = $urandom_range(0, 9);
         lo_t = sb.bp_x[0] - 512;
         hi_t = sb.bp_x[n-1] + 512;
         if (hi_t < lo_t) begin
            a    = lo_t;
            lo_t = hi_t;
            hi_t = a;
         end
         if (mode == 0) begin
            // stray write somewhere in the table
            write_point(4'($urandom_range(0, 15)), 16'($urandom), 16'($urandom));
         end else if (mode == 1) begin
            query_day(16'($urandom), 16'($urandom));
         end else if (mode == 2) begin
            // flat day right on a breakpoint
            a = sb.bp_x[$urandom_range(0, n - 1)];
            query_day(16'(a), 16'(a));
         end else begin
            a = lo_t + $urandom_range(0, hi_t - lo_t);
            b = lo_t + $urandom_range(0, hi_t - lo_t);
            // a reversed day now and then
            if ((a < b) == (mode != 3)) query_day(clamp16(b), clamp16(a));
            else query_day(clamp16(a), clamp16(b));
         end
      end
   endtask

   initial begin
      int i;
      int directed_beats;
      clock           = 1'b0;
      reset           = 1'b1;
      start           = 1'b0;
      req_opcode      = thti_pkg::OP_WRITE;
      req_point_index = '0;
      req_point_x     = '0;
      req_point_y     = '0;
      req_tmax        = '0;
      req_tmin        = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      beats_sent      = 0;
      cycle_count     = 0;
      phase_count     = 0;
      no_idle         = 1'b0;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset count of one point: only slot 0 is ever read
      write_point(4'd0, 16'sd0, 16'sd256);
      query_day(16'sd0, 16'sd0);
      query_day(16'sd32767, -16'sd32768);

      // full table with both extremes and a repeated x
      wait_for_idle();
      write_points_cfg(16);
      for (i = 0; i < TABLE_SLOTS; i++) write_point(4'(i), 16'(dir_x[i]), 16'(dir_y[i]));
      query_day(-16'sd32768, -16'sd32768);    // exact hit on the first x
      query_day(16'sd32767, 16'sd32767);      // exact hit on the last x
      query_day(16'sd512, 16'sd512);          // exact hit inside
      query_day(16'sd3000, -16'sd100);        // plain interpolation
      query_day(-16'sd32768, 16'sd32767);     // widest reversed day

      // above the last used point
      wait_for_idle();
      write_points_cfg(5);
      query_day(16'sd1000, 16'sd1000);

      // zero count behaves as one point
      wait_for_idle();
      write_points_cfg(0);
      query_day(16'sd500, -16'sd500);

      directed_beats = beats_sent;
      while (beats_sent < directed_beats + RANDOM_BEATS) run_phase();

      // drain, then give a stray late beat the chance to show up
      start <= 1'b0;
      while (sb.expected_factors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_factors.size() != 0)
         sb.report_mismatch($sformatf("%0d factors never came", sb.expected_factors.size()));
      if (sb.mismatches == 0)
         $display("[three_hourly_temperature_interpolation_unit] OK");
      else
         $display("[three_hourly_temperature_interpolation_unit] ERROR");
      $finish;
   end

endmodule

>>> sim.f
hdl/thti_pkg.sv
hdl/three_hourly_temperature_interpolation_unit.sv
test/tb_top.sv
